// ===== sv/uer_pkg.sv =====
// shared types, codes and constants for the ultrasonic echo ranger
`timescale 1ns / 1ps
package uer_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_FAILURE_LIMIT = 2'd2;
  localparam logic [1:0] REG_PERIOD_TICKS  = 2'd3;

  localparam int CFG_DATA_W = 20;
  localparam int CNT_W      = 20;
  localparam int WIDTH_W    = 16;
  localparam int DIST_W     = 14;
  localparam int FAIL_W     = 4;

  localparam logic [7:0]  TRIGGER_RESET = 8'd10;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
  localparam logic [3:0]  LIMIT_RESET   = 4'd3;
  localparam logic [19:0] PERIOD_RESET  = 20'd1000000;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

  // distance = floor(width * 1715 / 10000), kept as a running quotient
  localparam logic [DIST_W:0]   DIST_NUM = 15'd1715;
  localparam logic [DIST_W:0]   DIST_DEN = 15'd10000;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [3:0]  failure_limit;
    logic [19:0] period_ticks;
  } cfg_t;

  typedef struct packed {
    logic               trigger_level;
    logic               result_valid;
    logic               measure_ok;
    logic [WIDTH_W-1:0] pulse_width_us;
    logic [DIST_W-1:0]  distance_mm;
    logic               alarm_active;
    logic               alarm_raised;
    logic               reconnected;
  } res_t;

endpackage

// ===== sv/uer_if.sv =====
// tick and result channel interfaces
`timescale 1ns / 1ps
interface uer_tick_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       echo_level;

  modport source (output valid, action, echo_level, input ready);
  modport sink (input valid, action, echo_level, output ready);
endinterface

interface uer_result_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic        result_valid;
  logic        measure_ok;
  logic [15:0] pulse_width_us;
  logic [13:0] distance_mm;
  logic        alarm_active;
  logic        alarm_raised;
  logic        reconnected;

  modport source (output valid, trigger_level, result_valid, measure_ok, pulse_width_us,
                  distance_mm, alarm_active, alarm_raised, reconnected, input ready);
  modport sink (input valid, trigger_level, result_valid, measure_ok, pulse_width_us,
                distance_mm, alarm_active, alarm_raised, reconnected, output ready);
endinterface

// ===== sv/ultrasonic_echo_ranger_top.sv =====
// ultrasonic echo ranger top level: config registers, tick and result registers
`timescale 1ns / 1ps
// Usage: one word on the tick channel per microsecond tick, carrying the
// command (plain tick, start, stop) and the sampled echo pin level. Every
// accepted tick word yields exactly one result word: the trigger pin level
// for that tick, a finished-measurement flag with success, pulse width and
// distance in mm, and the alarm level with its raise and reconnect pulses.
// Configuration registers (trigger, timeout, failure limit, period) are
// written through cfg_write / cfg_index / cfg_data while no word is in flight.
// A tick word is captured in the input register, processed by the sequencer
// and lands in the result register, where its result word is offered until
// the receiver takes it. Throughput is one word per cycle while the result
// receiver keeps ready high; the sequencer state advances once per word.
// Distance is tracked as a running quotient during the echo, so no
// multiplier sits in the path.
// Reset clears the sequencer (not running, idle phase, no alarm), loads the
// register defaults and empties both word registers. When the result
// receiver stalls, the result word holds, one more tick word is taken into
// the input register, and then ready drops until the result is taken.
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  uer_tick_if.sink              tick,
  uer_result_if.source          result,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       tick_valid;
  logic [1:0] tick_action;
  logic       tick_echo;
  logic       result_valid;
  res_t       result_word;
  res_t       core_res;
  logic       advance;

  assign advance    = tick_valid && (!result_valid || result.ready);
  assign tick.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= TRIGGER_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.failure_limit <= LIMIT_RESET;
      cfg.period_ticks  <= PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TRIGGER_TICKS: cfg.trigger_ticks <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[15:0];
        REG_FAILURE_LIMIT: cfg.failure_limit <= cfg_data[3:0];
        REG_PERIOD_TICKS:  cfg.period_ticks  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_action <= tick.action;
      tick_echo   <= tick.echo_level;
    end
  end

  uer_core u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .action     (tick_action),
    .echo_level (tick_echo),
    .cfg        (cfg),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= core_res;
    end
  end

  assign result.valid          = result_valid;
  assign result.trigger_level  = result_word.trigger_level;
  assign result.result_valid   = result_word.result_valid;
  assign result.measure_ok     = result_word.measure_ok;
  assign result.pulse_width_us = result_word.pulse_width_us;
  assign result.distance_mm    = result_word.distance_mm;
  assign result.alarm_active   = result_word.alarm_active;
  assign result.alarm_raised   = result_word.alarm_raised;
  assign result.reconnected    = result_word.reconnected;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ready |-> !advance)
    else $error("pending result word overwritten");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed word not offered");

  a_held_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !advance |=> tick_valid && $stable(tick_action) && $stable(tick_echo))
    else $error("waiting tick word lost");

endmodule

// ===== sv/uer_core.sv =====
// ranging sequencer: phase control, echo timing, failure count and alarm
`timescale 1ns / 1ps
module uer_core
  import uer_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [1:0] action,
  input  logic       echo_level,
  input  cfg_t       cfg,
  output res_t       res
);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_MEAS, PH_WAIT} phase_t;

  logic               running, running_next;
  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   phase_counter, phase_counter_next;
  logic [WIDTH_W-1:0] width_counter, width_counter_next;
  logic [DIST_W-1:0]  dist_acc, dist_acc_next;
  logic [DIST_W-1:0]  dist_rem, dist_rem_next;
  logic               rise_seen, rise_seen_next;
  logic               echo_previous;
  logic [FAIL_W-1:0]  failure_count, failure_count_next;
  logic               alarm_flag, alarm_flag_next;

  always_comb begin
    logic              rise;
    logic              fall;
    logic              done;
    logic              success;
    logic [DIST_W:0]   rem_sum;
    logic [FAIL_W-1:0] lim;
    logic [FAIL_W:0]   fc_inc;

    rise    = echo_level & ~echo_previous;
    fall    = ~echo_level & echo_previous;
    done    = 1'b0;
    success = 1'b0;
    rem_sum = {1'b0, dist_rem} + DIST_NUM;
    lim     = (cfg.failure_limit == '0) ? FAIL_W'(1) : cfg.failure_limit;
    fc_inc  = {1'b0, failure_count} + (FAIL_W+1)'(1);

    running_next       = running;
    phase_next         = phase;
    phase_counter_next = phase_counter;
    width_counter_next = width_counter;
    dist_acc_next      = dist_acc;
    dist_rem_next      = dist_rem;
    rise_seen_next     = rise_seen;
    failure_count_next = failure_count;
    alarm_flag_next    = alarm_flag;
    res                = '0;

    if (action == ACT_START) begin
      running_next       = 1'b1;
      failure_count_next = '0;
      alarm_flag_next    = 1'b0;
      if (phase == PH_IDLE) begin
        phase_next         = PH_TRIG;
        phase_counter_next = '0;
      end
    end else if (action == ACT_STOP) begin
      running_next       = 1'b0;
      phase_next         = PH_IDLE;
      phase_counter_next = '0;
      width_counter_next = '0;
      dist_acc_next      = '0;
      dist_rem_next      = '0;
      rise_seen_next     = 1'b0;
    end

    if (running_next) begin
      if (phase_next == PH_IDLE) begin
        phase_next         = PH_TRIG;
        phase_counter_next = '0;
      end
      if (phase_next == PH_TRIG) begin
        res.trigger_level = 1'b1;
        if (phase_counter_next != CNT_MAX) phase_counter_next = phase_counter_next + 1'b1;
        if (phase_counter_next >= CNT_W'(cfg.trigger_ticks)) begin
          phase_next         = PH_MEAS;
          phase_counter_next = '0;
          width_counter_next = '0;
          dist_acc_next      = '0;
          dist_rem_next      = '0;
          rise_seen_next     = 1'b0;
        end
      end else if (phase_next == PH_MEAS) begin
        if (phase_counter_next != CNT_MAX) phase_counter_next = phase_counter_next + 1'b1;
        if (rise) begin
          rise_seen_next     = 1'b1;
          width_counter_next = '0;
          dist_acc_next      = '0;
          dist_rem_next      = '0;
        end else if (rise_seen_next && width_counter_next != WIDTH_MAX) begin
          width_counter_next = width_counter_next + 1'b1;
          // one more tick of width adds 0.1715 mm
          if (rem_sum >= DIST_DEN) begin
            dist_rem_next = DIST_W'(rem_sum - DIST_DEN);
            dist_acc_next = dist_acc_next + 1'b1;
          end else begin
            dist_rem_next = DIST_W'(rem_sum);
          end
        end
        if (fall) begin
          done    = 1'b1;
          success = rise_seen_next && (width_counter_next != '0);
        end else if (phase_counter_next >= CNT_W'(cfg.timeout_ticks)) begin
          done = 1'b1;
        end
        if (done) begin
          res.result_valid = 1'b1;
          if (success) begin
            res.measure_ok     = 1'b1;
            res.pulse_width_us = width_counter_next;
            res.distance_mm    = dist_acc_next;
            failure_count_next = '0;
            if (alarm_flag_next) begin
              alarm_flag_next  = 1'b0;
              res.reconnected  = 1'b1;
            end
          end else begin
            failure_count_next = (fc_inc >= {1'b0, lim}) ? lim : FAIL_W'(fc_inc);
            if (failure_count_next >= lim && !alarm_flag_next) begin
              alarm_flag_next  = 1'b1;
              res.alarm_raised = 1'b1;
            end
          end
          phase_next         = PH_WAIT;
          phase_counter_next = '0;
          width_counter_next = '0;
          dist_acc_next      = '0;
          dist_rem_next      = '0;
          rise_seen_next     = 1'b0;
        end
      end else begin
        if (phase_counter_next != CNT_MAX) phase_counter_next = phase_counter_next + 1'b1;
        if (phase_counter_next >= cfg.period_ticks) begin
          phase_next         = PH_TRIG;
          phase_counter_next = '0;
        end
      end
    end

    res.alarm_active = alarm_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      phase         <= PH_IDLE;
      phase_counter <= '0;
      width_counter <= '0;
      dist_acc      <= '0;
      dist_rem      <= '0;
      rise_seen     <= 1'b0;
      echo_previous <= 1'b0;
      failure_count <= '0;
      alarm_flag    <= 1'b0;
    end else if (en) begin
      running       <= running_next;
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      width_counter <= width_counter_next;
      dist_acc      <= dist_acc_next;
      dist_rem      <= dist_rem_next;
      rise_seen     <= rise_seen_next;
      echo_previous <= echo_level;
      failure_count <= failure_count_next;
      alarm_flag    <= alarm_flag_next;
    end
  end

  a_stop_idles: assert property (@(posedge clk) disable iff (rst)
    en && action == ACT_STOP |=> phase == PH_IDLE && !running)
    else $error("stop word did not return to idle");

  a_raised_sets_alarm: assert property (@(posedge clk) disable iff (rst)
    en && res.alarm_raised |-> res.alarm_active && !res.reconnected)
    else $error("alarm pulse without alarm level");

  a_no_result_no_data: assert property (@(posedge clk) disable iff (rst)
    en && !res.result_valid |-> res.pulse_width_us == '0 && res.distance_mm == '0)
    else $error("result data without a finished measurement");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, dist_rem} < DIST_DEN)
    else $error("distance remainder out of range");

  a_fail_bounded: assert property (@(posedge clk) disable iff (rst)
    en && res.result_valid && !res.measure_ok |=> failure_count != '0)
    else $error("failure not counted");

endmodule

// ===== bench/tb_ultrasonic_echo_ranger_top.sv =====
// testbench for the ultrasonic echo ranger: tick driver, result checker, built-in predictor
`timescale 1ns / 1ps
module tb_ultrasonic_echo_ranger_top
  import uer_pkg::*;
;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum logic [1:0] {PH_IDLE, PH_TRIGGER, PH_MEASURE, PH_WAIT} seq_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic       echo;
  } tick_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = REG_TRIGGER_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic       send_valid = 1'b0;
  logic [1:0] send_action = ACT_TICK;
  logic       send_echo = 1'b0;
  logic       take_ready = 1'b0;

  uer_tick_if   tick_ch ();
  uer_result_if res_ch ();

  assign tick_ch.valid      = send_valid;
  assign tick_ch.action     = send_action;
  assign tick_ch.echo_level = send_echo;
  assign res_ch.ready       = take_ready;

  ultrasonic_echo_ranger_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ranger state as the block should hold it
  cfg_t                ranger_cfg;
  logic                rng_running;
  seq_phase_t          rng_phase;
  logic [CNT_W-1:0]    phase_cnt;
  logic [WIDTH_W-1:0]  echo_width;
  logic                rise_seen;
  logic                echo_prev;
  logic [FAIL_W-1:0]   fail_run;
  logic                alarm_on;

  tick_word_t pending_ticks[$];
  res_t       expected_results[$];

  tick_word_t next_word;
  res_t       mon_got;
  res_t       mon_want;
  int         gap_left = 0;
  int         stall_left = 0;
  int         send_calm = 0;
  int         recv_calm = 0;
  int         bad_count = 0;

  initial forever #4 clk = ~clk;

  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pause_len(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic res_t ranger_tick(input logic [1:0] act, input logic echo);
    res_t        r;
    logic        rise;
    logic        fall;
    logic        done;
    logic        success;
    logic [4:0]  lim;
    logic [4:0]  next_fail;
    logic [31:0] prod;
    logic [31:0] quot;
    r = '0;
    done = 1'b0;
    success = 1'b0;
    rise = echo & ~echo_prev;
    fall = ~echo & echo_prev;
    echo_prev = echo;

    if (act == ACT_START) begin
      rng_running = 1'b1;
      fail_run = '0;
      alarm_on = 1'b0;
      if (rng_phase == PH_IDLE) begin
        rng_phase = PH_TRIGGER;
        phase_cnt = '0;
      end
    end else if (act == ACT_STOP) begin
      rng_running = 1'b0;
      rng_phase = PH_IDLE;
      phase_cnt = '0;
      echo_width = '0;
      rise_seen = 1'b0;
    end

    if (rng_running) begin
      if (rng_phase == PH_IDLE) begin
        rng_phase = PH_TRIGGER;
        phase_cnt = '0;
      end
      case (rng_phase)
        PH_TRIGGER: begin
          r.trigger_level = 1'b1;
          phase_cnt = (phase_cnt == CNT_MAX) ? CNT_MAX : phase_cnt + 1'b1;
          if (phase_cnt >= ranger_cfg.trigger_ticks) begin
            rng_phase = PH_MEASURE;
            phase_cnt = '0;
            echo_width = '0;
            rise_seen = 1'b0;
          end
        end
        PH_MEASURE: begin
          phase_cnt = (phase_cnt == CNT_MAX) ? CNT_MAX : phase_cnt + 1'b1;
          if (rise) begin
            rise_seen = 1'b1;
            echo_width = '0;
          end else if (rise_seen) begin
            echo_width = (echo_width == WIDTH_MAX) ? WIDTH_MAX : echo_width + 1'b1;
          end
          if (fall) begin
            done = 1'b1;
            success = rise_seen && (echo_width != 0);
          end else if (phase_cnt >= ranger_cfg.timeout_ticks) begin
            done = 1'b1;
          end
          if (done) begin
            r.result_valid = 1'b1;
            if (success) begin
              r.measure_ok = 1'b1;
              r.pulse_width_us = echo_width;
              prod = {16'd0, echo_width} * 32'd1715;
              quot = prod / 32'd10000;
              r.distance_mm = quot[DIST_W-1:0];
              fail_run = '0;
              if (alarm_on) begin
                alarm_on = 1'b0;
                r.reconnected = 1'b1;
              end
            end else begin
              lim = (ranger_cfg.failure_limit == 0) ? 5'd1 : {1'b0, ranger_cfg.failure_limit};
              next_fail = {1'b0, fail_run} + 5'd1;
              if (next_fail >= lim) next_fail = lim;
              fail_run = next_fail[FAIL_W-1:0];
              if (next_fail >= lim && !alarm_on) begin
                alarm_on = 1'b1;
                r.alarm_raised = 1'b1;
              end
            end
            rng_phase = PH_WAIT;
            phase_cnt = '0;
            echo_width = '0;
            rise_seen = 1'b0;
          end
        end
        default: begin
          phase_cnt = (phase_cnt == CNT_MAX) ? CNT_MAX : phase_cnt + 1'b1;
          if (phase_cnt >= ranger_cfg.period_ticks) begin
            rng_phase = PH_TRIGGER;
            phase_cnt = '0;
          end
        end
      endcase
    end
    r.alarm_active = alarm_on;
    return r;
  endfunction

  task automatic report_mismatch(input string why, input res_t want, input res_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%s at %0t", why, $realtime);
      $display("  want trig=%0d valid=%0d ok=%0d width=%0d mm=%0d alarm=%0d raised=%0d recon=%0d",
               want.trigger_level, want.result_valid, want.measure_ok,
               want.pulse_width_us, want.distance_mm, want.alarm_active, want.alarm_raised,
               want.reconnected);
      $display("  got  trig=%0d valid=%0d ok=%0d width=%0d mm=%0d alarm=%0d raised=%0d recon=%0d",
               got.trigger_level, got.result_valid, got.measure_ok, got.pulse_width_us,
               got.distance_mm, got.alarm_active, got.alarm_raised, got.reconnected);
    end
  endtask

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (send_valid && tick_ch.ready) expected_results.push_back(ranger_tick(send_action, send_echo));
      if (!send_valid || tick_ch.ready) begin
        if (gap_left > 0 || pending_ticks.size() == 0) begin
          if (gap_left > 0) gap_left--;
          send_valid <= 1'b0;
        end else begin
          next_word = pending_ticks.pop_front();
          send_valid <= 1'b1;
          send_action <= next_word.action;
          send_echo <= next_word.echo;
          gap_left = pause_len(send_calm);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      take_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && take_ready) begin
        mon_got = {res_ch.trigger_level, res_ch.result_valid, res_ch.measure_ok,
                   res_ch.pulse_width_us, res_ch.distance_mm, res_ch.alarm_active,
                   res_ch.alarm_raised, res_ch.reconnected};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", '0, mon_got);
        end else begin
          mon_want = expected_results.pop_front();
          if (mon_got !== mon_want) report_mismatch("result mismatch", mon_want, mon_got);
        end
        stall_left = pause_len(recv_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(input logic [1:0] act, input logic lvl);
    pending_ticks.push_back({act, lvl});
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TRIGGER_TICKS: ranger_cfg.trigger_ticks = data[7:0];
      REG_TIMEOUT_TICKS: ranger_cfg.timeout_ticks = data[15:0];
      REG_FAILURE_LIMIT: ranger_cfg.failure_limit = data[3:0];
      default: ranger_cfg.period_ticks = data[19:0];
    endcase
  endtask

  task automatic program_ranger(input logic [7:0] trig, input logic [15:0] tmo,
                                input logic [3:0] lim, input logic [19:0] per, input bit junk);
    logic [19:0] pad;
    pad = junk ? 20'($urandom) : 20'd0;
    write_reg(REG_TRIGGER_TICKS, {pad[19:8], trig});
    write_reg(REG_TIMEOUT_TICKS, {pad[19:16], tmo});
    write_reg(REG_FAILURE_LIMIT, {pad[19:4], lim});
    write_reg(REG_PERIOD_TICKS, per);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every word is sent and every result has come back
  task automatic settle();
    while (pending_ticks.size() != 0 || send_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_echo_train(input int words, input int low_max, input int high_max,
                                  input int cmd_per_mille);
    logic       level;
    logic [1:0] act;
    int         run;
    int         k;
    int         pick;
    level = 1'($urandom_range(0, 1));
    k = 0;
    while (k < words) begin
      run = level ? $urandom_range(1, high_max) : $urandom_range(1, low_max);
      for (int j = 0; j < run && k < words; j++) begin
        pick = $urandom_range(0, 999);
        act = ACT_TICK;
        if (pick < cmd_per_mille) begin
          case ($urandom_range(0, 2))
            0: act = ACT_START;
            1: act = ACT_STOP;
            default: act = ACT_SPARE;
          endcase
        end
        queue_word(act, level);
        k++;
      end
      level = ~level;
    end
  endtask

  initial begin
    logic [7:0]  trig;
    logic [15:0] tmo;
    logic [3:0]  lim;
    logic [19:0] per;
    int          lo;
    int          hi;
    int          cmd;

    ranger_cfg = '{TRIGGER_RESET, TIMEOUT_RESET, LIMIT_RESET, PERIOD_RESET};
    rng_running = 1'b0;
    rng_phase = PH_IDLE;
    phase_cnt = '0;
    echo_width = '0;
    rise_seen = 1'b0;
    echo_prev = 1'b0;
    fail_run = '0;
    alarm_on = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: idle ticks, then a trigger pulse cut short by stop
    queue_word(ACT_TICK, 1'b0);
    queue_word(ACT_STOP, 1'b1);
    queue_word(ACT_START, 1'b0);
    repeat (3) queue_word(ACT_TICK, 1'b0);
    queue_word(ACT_STOP, 1'b0);
    settle();

    // fall without rise, alarm, reconnect, start mid-measure, timeout, spare code
    program_ranger(8'd1, 16'd6, 4'd1, 20'd2, 1'b0);
    queue_word(ACT_START, 1'b1);
    queue_word(ACT_TICK, 1'b0);
    repeat (3) queue_word(ACT_TICK, 1'b0);
    queue_word(ACT_TICK, 1'b1);
    queue_word(ACT_TICK, 1'b1);
    queue_word(ACT_TICK, 1'b0);
    repeat (3) queue_word(ACT_TICK, 1'b0);
    queue_word(ACT_SPARE, 1'b0);
    queue_word(ACT_START, 1'b1);
    queue_word(ACT_TICK, 1'b0);
    repeat (10) queue_word(ACT_TICK, 1'b0);
    queue_word(ACT_STOP, 1'b1);
    settle();

    // all registers zero
    program_ranger(8'd0, 16'd0, 4'd0, 20'd0, 1'b0);
    queue_word(ACT_START, 1'b0);
    queue_echo_train(30, 3, 3, 0);
    queue_word(ACT_STOP, 1'b1);
    settle();

    // largest settings with a long echo
    program_ranger(8'd255, 16'd65535, 4'd15, 20'd1048575, 1'b0);
    queue_word(ACT_START, 1'b0);
    repeat (254) queue_word(ACT_TICK, 1'b0);
    repeat (300) queue_word(ACT_TICK, 1'b1);
    queue_word(ACT_TICK, 1'b0);
    repeat (20) queue_word(ACT_TICK, 1'b0);
    queue_word(ACT_STOP, 1'b0);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        3: begin
          trig = 8'($urandom_range(1, 3));
          tmo = 16'($urandom_range(1, 10));
          lim = 4'($urandom_range(12, 15));
          per = 20'($urandom_range(1, 5));
          lo = 400;
          hi = 3;
          cmd = 2;
        end
        4: begin
          trig = 8'($urandom_range(1, 20));
          tmo = 16'($urandom_range(2, 30));
          lim = 4'($urandom_range(1, 4));
          per = 20'($urandom_range(1, 10));
          lo = 8;
          hi = 80;
          cmd = 5;
        end
        5: begin
          trig = 8'($urandom_range(1, 6));
          tmo = 16'($urandom_range(10, 60));
          lim = 4'($urandom_range(1, 6));
          per = 20'($urandom_range(1, 8));
          lo = 25;
          hi = 25;
          cmd = 40;
        end
        default: begin
          trig = 8'($urandom_range(1, 12));
          tmo = 16'($urandom_range(16, 400));
          lim = 4'($urandom_range(1, 15));
          per = 20'($urandom_range(1, 40));
          lo = tmo / 3 + 1;
          hi = tmo / 3 + 1;
          cmd = 8;
        end
      endcase
      program_ranger(trig, tmo, lim, per, 1'($urandom_range(0, 1)));
      if (!rng_running || $urandom_range(0, 1)) queue_word(ACT_START, 1'($urandom_range(0, 1)));
      queue_echo_train(200, lo, hi, cmd);
      if ($urandom_range(0, 1)) queue_word(ACT_STOP, 1'($urandom_range(0, 1)));
      settle();
    end

    repeat (8) @(negedge clk);
    if (bad_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/uer_pkg.sv
sv/uer_if.sv
sv/uer_core.sv
sv/ultrasonic_echo_ranger_top.sv
bench/tb_ultrasonic_echo_ranger_top.sv
